/* src/fbsa_pkg.sv */
// fbsa_pkg: shared types and constants for the frame buffer slot allocator.
// Holds field widths, command/status codes, sequencer states and the structs
// passed between the slot store, the scan unit and the top level.
`timescale 1ns / 1ps

package fbsa_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned HANDLE_W      = 32;
  localparam int unsigned DIM_W         = 16;
  localparam int unsigned STRIDE_W      = 18;

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_VIEW    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_CLOSED      = 3'd1,
    STS_INVALID     = 3'd2,
    STS_UNSUPPORTED = 3'd3,
    STS_NO_SLOT     = 3'd4,
    STS_NOT_FOUND   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_RESP
  } fsm_e;

  // Stored geometry of one slot.
  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [STRIDE_W-1:0] stride;
  } geom_t;

  // Scan unit status toward the sequencer.
  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

  // Sequencer controls, decoded from the state.
  typedef struct packed {
    logic scan_start;
    logic alloc_we;
    logic free_we;
    logic load_early;
    logic load_scan;
    logic load_geom;
    logic out_valid;
  } ctrl_t;

endpackage

/* src/frame_buffer_slot_allocator_core.sv */
// frame_buffer_slot_allocator_core: top level of the frame buffer slot pool.
// Instantiates fbsa_slot_store and fbsa_scan_unit; uses fbsa_pkg.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+------------------------------------
//   in       | in_valid_i / in_stall_o   | cmd, handle, req_width, req_height,
//            |                           | pixel_kind, mem_place
//   out      | out_valid_o / out_stall_i | status, out_handle, out_width,
//            |                           | out_height, out_stride
//   cfg      | cfg_we_i                  | cfg_wdata_i (store_closed)
//
// One transaction at a time; a failed argument check answers in the cycle after acceptance.
// A slot search compares one slot per cycle after a registered handle read and stops at the first
// slot that decides or at the last slot. A view that finds its handle adds one geometry read.
// The response register holds the result until the out transaction completes.
// Reset clears busy flags, store_closed and the handle counter (to 1); no memory clearing pass.
// in_stall_o is high after acceptance until the result has been taken.
`timescale 1ns / 1ps

module frame_buffer_slot_allocator_core import fbsa_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [DIM_W-1:0]    req_width_i,
  input  logic [DIM_W-1:0]    req_height_i,
  input  logic [2:0]          pixel_kind_i,
  input  logic [1:0]          mem_place_i,
  // response channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [DIM_W-1:0]    out_width_o,
  output logic [DIM_W-1:0]    out_height_o,
  output logic [STRIDE_W-1:0] out_stride_o
);

  fsm_e                state_q, state_d;
  ctrl_t               ctrl;
  logic                store_closed_q;
  logic [HANDLE_W-1:0] hcnt_q, hcnt_d;

  // Request held for the duration of the transaction.
  logic [1:0]          req_cmd_q;
  logic [HANDLE_W-1:0] req_handle_q;
  logic [DIM_W-1:0]    req_w_q;
  logic [DIM_W-1:0]    req_h_q;

  // Response register.
  status_e             status_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic [DIM_W-1:0]    out_w_q;
  logic [DIM_W-1:0]    out_h_q;
  logic [STRIDE_W-1:0] out_s_q;

  status_e             early_status;
  logic                need_scan;
  logic                is_acquire;
  logic                is_view;
  logic                is_release;

  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    slot_idx;
  logic [HANDLE_W-1:0] hdl_rd;
  logic                busy_bit;
  geom_t               geom_rd;
  geom_t               wr_geom;
  scan_stat_t          scan_stat;

  // Argument checks in the order the command defines; any failure answers
  // without touching the slots.
  always_comb begin
    early_status = STS_INVALID;
    need_scan    = 1'b0;
    unique case (cmd_e'(cmd_i))
      CMD_ACQUIRE: begin
        if (store_closed_q) begin
          early_status = STS_CLOSED;
        end else if (mem_place_i != 2'd0) begin
          early_status = STS_INVALID;
        end else if (pixel_kind_i != 3'd0) begin
          early_status = STS_UNSUPPORTED;
        end else if ((req_width_i == '0) || (req_height_i == '0)) begin
          early_status = STS_INVALID;
        end else begin
          need_scan = 1'b1;
        end
      end
      CMD_VIEW: begin
        // a zero handle is rejected even when the store is closed
        if (handle_i == '0) begin
          early_status = STS_INVALID;
        end else if (store_closed_q) begin
          early_status = STS_CLOSED;
        end else begin
          need_scan = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (handle_i == '0) begin
          early_status = STS_INVALID;
        end else begin
          need_scan = 1'b1;
        end
      end
      default: begin
        early_status = STS_INVALID;
      end
    endcase
  end

  assign is_acquire = (req_cmd_q == CMD_ACQUIRE);
  assign is_view    = (req_cmd_q == CMD_VIEW);
  assign is_release = (req_cmd_q == CMD_RELEASE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = need_scan ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          state_d = (scan_stat.hit && is_view) ? S_FETCH : S_RESP;
        end
      end
      S_FETCH: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Controls per state.
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      S_IDLE: begin
        ctrl.load_early = in_valid_i;
        ctrl.scan_start = in_valid_i && need_scan;
      end
      S_SCAN: begin
        ctrl.load_scan = scan_stat.done;
        ctrl.alloc_we  = scan_stat.done && scan_stat.hit && is_acquire;
        ctrl.free_we   = scan_stat.done && scan_stat.hit && is_release;
      end
      S_FETCH: begin
        ctrl.load_geom = 1'b1;
      end
      S_RESP: begin
        ctrl.out_valid = 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // Advance the handle counter on each allocation; wrap past all ones to 1.
  always_comb begin
    hcnt_d = hcnt_q;
    if (ctrl.alloc_we) begin
      hcnt_d = (hcnt_q == '1) ? HANDLE_W'(1) : hcnt_q + HANDLE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      store_closed_q <= 1'b0;
      hcnt_q         <= HANDLE_W'(1);
    end else begin
      state_q <= state_d;
      hcnt_q  <= hcnt_d;
      if (cfg_we_i) begin
        store_closed_q <= cfg_wdata_i;
      end
    end
  end

  // Capture the request on acceptance.
  always_ff @(posedge clk_i) begin
    if (ctrl.load_early) begin
      req_cmd_q    <= cmd_i;
      req_handle_q <= handle_i;
      req_w_q      <= req_width_i;
      req_h_q      <= req_height_i;
    end
  end

  // Response register: default fields to zero, fill in as the request resolves.
  always_ff @(posedge clk_i) begin
    if (ctrl.load_early) begin
      status_q     <= early_status;
      out_handle_q <= '0;
      out_w_q      <= '0;
      out_h_q      <= '0;
      out_s_q      <= '0;
    end else if (ctrl.load_scan) begin
      if (scan_stat.hit) begin
        status_q     <= STS_OK;
        out_handle_q <= is_acquire ? hcnt_q : req_handle_q;
      end else begin
        status_q <= is_acquire ? STS_NO_SLOT : STS_NOT_FOUND;
      end
    end else if (ctrl.load_geom) begin
      out_w_q <= geom_rd.width;
      out_h_q <= geom_rd.height;
      out_s_q <= geom_rd.stride;
    end
  end

  // Stride is width times three: shift and add.
  always_comb begin
    wr_geom.width  = req_w_q;
    wr_geom.height = req_h_q;
    wr_geom.stride = STRIDE_W'({req_w_q, 1'b0}) + STRIDE_W'(req_w_q);
  end

  fbsa_scan_unit #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (ctrl.scan_start),
    .find_free_i (is_acquire),
    .key_i       (req_handle_q),
    .busy_i      (busy_bit),
    .hdl_i       (hdl_rd),
    .rd_addr_o   (rd_addr),
    .idx_o       (slot_idx),
    .stat_o      (scan_stat)
  );

  fbsa_slot_store #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_addr_i   (rd_addr),
    .slot_idx_i  (slot_idx),
    .alloc_i     (ctrl.alloc_we),
    .free_i      (ctrl.free_we),
    .wr_handle_i (hcnt_q),
    .wr_geom_i   (wr_geom),
    .hdl_rd_o    (hdl_rd),
    .busy_o      (busy_bit),
    .geom_rd_o   (geom_rd)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = ctrl.out_valid;
  assign status_o     = status_q;
  assign out_handle_o = out_handle_q;
  assign out_width_o  = out_w_q;
  assign out_height_o = out_h_q;
  assign out_stride_o = out_s_q;

endmodule

/* src/fbsa_slot_store.sv */
// fbsa_slot_store: per-slot busy flags, handle memory and geometry memory.
// Depends on fbsa_pkg for geom_t and field widths.
`timescale 1ns / 1ps

module fbsa_slot_store import fbsa_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IDX_W-1:0]    rd_addr_i,
  input  logic [IDX_W-1:0]    slot_idx_i,
  input  logic                alloc_i,
  input  logic                free_i,
  input  logic [HANDLE_W-1:0] wr_handle_i,
  input  geom_t               wr_geom_i,
  output logic [HANDLE_W-1:0] hdl_rd_o,
  output logic                busy_o,
  output geom_t               geom_rd_o
);

  logic [NUM_SLOTS-1:0] busy_q;
  logic [NUM_SLOTS-1:0] busy_d;
  logic [HANDLE_W-1:0]  hdl_mem [NUM_SLOTS];
  geom_t                geom_mem [NUM_SLOTS];

  always_comb begin
    busy_d = busy_q;
    if (alloc_i) begin
      busy_d[slot_idx_i] = 1'b1;
    end else if (free_i) begin
      busy_d[slot_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // Handle memory: one write port, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      hdl_mem[slot_idx_i] <= wr_handle_i;
    end
    hdl_rd_o <= hdl_mem[rd_addr_i];
  end

  // Geometry memory: read at the slot under compare into a registered output.
  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      geom_mem[slot_idx_i] <= wr_geom_i;
    end
    geom_rd_o <= geom_mem[slot_idx_i];
  end

  assign busy_o = busy_q[slot_idx_i];

endmodule

/* src/fbsa_scan_unit.sv */
// fbsa_scan_unit: walks the slots one per cycle with a single shared compare.
// Finds the lowest free slot or the lowest busy slot holding a key handle.
// Depends on fbsa_pkg for scan_stat_t and HANDLE_W.
`timescale 1ns / 1ps

module fbsa_scan_unit import fbsa_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                find_free_i,
  input  logic [HANDLE_W-1:0] key_i,
  input  logic                busy_i,
  input  logic [HANDLE_W-1:0] hdl_i,
  output logic [IDX_W-1:0]    rd_addr_o,
  output logic [IDX_W-1:0]    idx_o,
  output scan_stat_t          stat_o
);

  logic             active_q, active_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             issue;
  logic             hit;
  logic             last;

  always_comb begin
    hit  = cmp_vld_q && (find_free_i ? !busy_i : (busy_i && (hdl_i == key_i)));
    last = (cmp_idx_q == IDX_W'(NUM_SLOTS - 1));
    stat_o.hit  = hit;
    stat_o.done = cmp_vld_q && (hit || last);
    issue = active_q && (cnt_q < CNT_W'(NUM_SLOTS));
  end

  always_comb begin
    active_d  = active_q;
    cnt_d     = cnt_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
    end else if (stat_o.done) begin
      active_d = 1'b0;
    end else if (issue) begin
      cmp_vld_d = 1'b1;
      cmp_idx_d = cnt_q[IDX_W-1:0];
      cnt_d     = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      active_q  <= active_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
    end
  end

  assign rd_addr_o = cnt_q[IDX_W-1:0];
  assign idx_o     = cmp_idx_q;

endmodule
